@@ hdl/bebs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bebs_pkg - bit error burst statistics shared definitions
// Request and result layouts, sizing constants and saturating helpers.
// ----------------------------------------------------------------------------
package bebs_pkg;

    localparam int MAX_POSITIONS = 256;
    localparam int RUN_BINS      = 32;

    localparam int SOFT_W = 16;
    localparam int CNT_W  = 32;
    localparam int SUM_W  = 48;
    localparam int IDX_W  = 8;

    localparam int ADDR_W = $clog2(MAX_POSITIONS);
    localparam int POS_W  = $clog2(MAX_POSITIONS + 1);
    localparam int RUN_W  = $clog2(RUN_BINS + 1);

    typedef enum logic [1:0] {
        REQ_COMPARE   = 2'd0,
        REQ_READ_POS  = 2'd1,
        REQ_READ_HIST = 2'd2,
        REQ_NONE      = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type                 req_type;
        logic signed [SOFT_W-1:0]  soft_value;
        logic                      expected_bit;
        logic                      last_bit;
        logic [IDX_W-1:0]          read_index;
    } t_in_req;

    typedef struct packed {
        logic               bit_error;
        logic [SOFT_W-1:0]  margin;
        logic [CNT_W-1:0]   capture_errors;
        logic [CNT_W-1:0]   total_bits;
        logic [CNT_W-1:0]   total_errors;
        logic [CNT_W-1:0]   errors_zero_to_one;
        logic [CNT_W-1:0]   errors_one_to_zero;
        logic [SUM_W-1:0]   margin_sum_correct;
        logic [SUM_W-1:0]   margin_sum_errored;
        logic [CNT_W-1:0]   clean_captures;
        logic [CNT_W-1:0]   read_count_a;
        logic [CNT_W-1:0]   read_count_b;
    } t_out_res;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0]  s,
                                                 input logic [SOFT_W-1:0] a);
        logic [SUM_W:0] t;
        t = {1'b0, s} + (SUM_W + 1)'(a);
        return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ hdl/bit_error_burst_statistics_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bit_error_burst_statistics_top - bit error rate tester with burst statistics
// Compares soft decisions with known bits, keeps per-position counters,
// totals, margin sums, a run length histogram and clean capture count.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle while o_in_stall is low; the
// accepting edge reads the per-position counter memories and the histogram
// memory (registered read, with bypass of the write made by the request
// ahead), then stage 1 does the read-modify-write and updates the totals
// into the result register. Bit position and open run length are
// tracked at acceptance so the histogram bin is known before the read. All
// stores read as zero after reset through per-entry valid bits, so there is
// no clearing pass. A compare past the position bound only reports bit_error
// and margin, but its last_bit still ends the capture. Counters saturate.
// ----------------------------------------------------------------------------
module bit_error_burst_statistics_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire bebs_pkg::t_in_req  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output bebs_pkg::t_out_res      o_out_data
);
    import bebs_pkg::*;

    // handshake
    logic acc, s1_move, s1_fire;
    logic r_s1_vld, r_out_vld;
    t_out_res r_out_data;

    // tracked at acceptance
    logic [POS_W-1:0] r_pos;
    logic [RUN_W-1:0] r_run;

    // request decode
    logic [SOFT_W-1:0] raw, in_margin;
    logic in_neg, in_err, in_cmp, in_range;
    logic [RUN_W-1:0] run_step, run_next, hist_bin;
    logic close_a, close_b, hist_close;
    logic [POS_W-1:0] pos_next;
    logic [ADDR_W-1:0] pos_addr;
    logic pos_rdok, hist_rdok;
    logic [RUN_W-1:0] hist_rd_addr;

    // stage 1
    t_req_type r_s1_req;
    logic r_s1_err, r_s1_want, r_s1_last, r_s1_inr, r_s1_rdok;
    logic [SOFT_W-1:0] r_s1_margin;
    logic [ADDR_W-1:0] r_s1_pos_addr;
    logic r_s1_hist_we, r_s1_hist_rdok;
    logic [RUN_W-1:0] r_s1_hist_bin;

    // position counter memories
    logic [CNT_W-1:0] r_pe_mem [MAX_POSITIONS];
    logic [CNT_W-1:0] r_pb_mem [MAX_POSITIONS];
    logic [MAX_POSITIONS-1:0] r_pv;
    logic [CNT_W-1:0] r_pe_rd, r_pb_rd, r_pe_byp, r_pb_byp;
    logic r_pos_hit, r_pos_ok;
    logic [CNT_W-1:0] pe_cur, pb_cur, pe_wdata, pb_wdata;
    logic pos_we;

    // histogram memory
    logic [CNT_W-1:0] r_h_mem [RUN_BINS+1];
    logic [RUN_BINS:0] r_hv;
    logic [CNT_W-1:0] r_ha_rd, r_hb_rd, r_ha_byp, r_hb_byp;
    logic r_ha_hit, r_ha_ok, r_hb_hit, r_hb_ok;
    logic [CNT_W-1:0] ha_cur, hb_cur, h_wdata;
    logic h_we;

    // totals
    logic [CNT_W-1:0] r_cap_err, r_bit_total, r_err_total, r_z2o, r_o2z, r_clean;
    logic [SUM_W-1:0] r_sum_ok, r_sum_err;
    logic [CNT_W-1:0] n_cap_err, n_bit_total, n_err_total, n_z2o, n_o2z, n_clean;
    logic [SUM_W-1:0] n_sum_ok, n_sum_err;
    t_out_res n_res;

    assign s1_move     = !r_out_vld || !i_out_stall;
    assign s1_fire     = r_s1_vld && s1_move;
    assign o_in_stall  = r_s1_vld && !s1_move;
    assign acc         = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    // ------------------------------------------------------------------
    // decode at acceptance
    // ------------------------------------------------------------------
    always_comb begin
        raw       = i_in_data.soft_value;
        in_neg    = raw[SOFT_W-1];
        in_margin = in_neg ? (~raw + 1'b1) : raw;
        in_err    = (!in_neg && (raw != '0)) != i_in_data.expected_bit;
        in_cmp    = (i_in_data.req_type == REQ_COMPARE);
        in_range  = r_pos < POS_W'(MAX_POSITIONS);

        run_step = r_run;
        close_a  = 1'b0;
        if (in_range) begin
            if (in_err) begin
                run_step = (r_run < RUN_W'(RUN_BINS)) ? r_run + 1'b1 : r_run;
            end else begin
                close_a  = (r_run != '0);
                run_step = '0;
            end
        end
        close_b    = i_in_data.last_bit && (run_step != '0);
        hist_close = in_cmp && (close_a || close_b);
        hist_bin   = close_a ? r_run : run_step;
        run_next   = i_in_data.last_bit ? '0 : run_step;

        pos_next = in_range ? r_pos + 1'b1 : r_pos;
        if (i_in_data.last_bit) begin
            pos_next = '0;
        end

        pos_addr     = in_cmp ? ADDR_W'(r_pos) : ADDR_W'(i_in_data.read_index);
        pos_rdok     = 32'(i_in_data.read_index) < 32'(MAX_POSITIONS);
        hist_rd_addr = RUN_W'(i_in_data.read_index);
        hist_rdok    = (i_in_data.read_index != '0)
                    && (32'(i_in_data.read_index) <= 32'(RUN_BINS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_run <= '0;
        end else if (acc && in_cmp) begin
            r_pos <= pos_next;
            r_run <= run_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_req       <= i_in_data.req_type;
            r_s1_err       <= in_err;
            r_s1_margin    <= in_margin;
            r_s1_want      <= i_in_data.expected_bit;
            r_s1_last      <= i_in_data.last_bit;
            r_s1_inr       <= in_range;
            r_s1_rdok      <= pos_rdok;
            r_s1_pos_addr  <= pos_addr;
            r_s1_hist_we   <= hist_close;
            r_s1_hist_bin  <= hist_bin;
            r_s1_hist_rdok <= hist_rdok;
        end
    end

    // ------------------------------------------------------------------
    // memories: read at acceptance, written back from stage 1
    // ------------------------------------------------------------------
    assign pe_cur   = r_pos_hit ? r_pe_byp : (r_pos_ok ? r_pe_rd : '0);
    assign pb_cur   = r_pos_hit ? r_pb_byp : (r_pos_ok ? r_pb_rd : '0);
    assign pos_we   = s1_fire && (r_s1_req == REQ_COMPARE) && r_s1_inr;
    assign pe_wdata = r_s1_err ? sat_inc(pe_cur) : pe_cur;
    assign pb_wdata = sat_inc(pb_cur);

    assign ha_cur  = r_ha_hit ? r_ha_byp : (r_ha_ok ? r_ha_rd : '0);
    assign hb_cur  = r_hb_hit ? r_hb_byp : (r_hb_ok ? r_hb_rd : '0);
    assign h_we    = s1_fire && r_s1_hist_we;
    assign h_wdata = sat_inc(ha_cur);

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            r_pe_mem[r_s1_pos_addr] <= pe_wdata;
            r_pb_mem[r_s1_pos_addr] <= pb_wdata;
        end
        if (acc) begin
            r_pe_rd <= r_pe_mem[pos_addr];
            r_pb_rd <= r_pb_mem[pos_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            r_h_mem[r_s1_hist_bin] <= h_wdata;
        end
        if (acc) begin
            r_ha_rd <= r_h_mem[hist_bin];
            r_hb_rd <= r_h_mem[hist_rd_addr];
        end
    end

    // write-first bypass of the stage 1 write
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_pos_hit <= pos_we && (r_s1_pos_addr == pos_addr);
            r_pos_ok  <= r_pv[pos_addr];
            r_pe_byp  <= pe_wdata;
            r_pb_byp  <= pb_wdata;
            r_ha_hit  <= h_we && (r_s1_hist_bin == hist_bin);
            r_ha_ok   <= r_hv[hist_bin];
            r_ha_byp  <= h_wdata;
            r_hb_hit  <= h_we && (r_s1_hist_bin == hist_rd_addr);
            r_hb_ok   <= r_hv[hist_rd_addr];
            r_hb_byp  <= h_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
            r_hv <= '0;
        end else begin
            if (pos_we) begin
                r_pv[r_s1_pos_addr] <= 1'b1;
            end
            if (h_we) begin
                r_hv[r_s1_hist_bin] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: totals and result
    // ------------------------------------------------------------------
    always_comb begin
        n_cap_err   = r_cap_err;
        n_bit_total = r_bit_total;
        n_err_total = r_err_total;
        n_z2o       = r_z2o;
        n_o2z       = r_o2z;
        n_clean     = r_clean;
        n_sum_ok    = r_sum_ok;
        n_sum_err   = r_sum_err;
        n_res       = '0;
        n_res.capture_errors = r_cap_err;

        case (r_s1_req)
            REQ_COMPARE: begin
                n_res.bit_error = r_s1_err;
                n_res.margin    = r_s1_margin;
                if (r_s1_inr) begin
                    n_bit_total = sat_inc(r_bit_total);
                    if (r_s1_err) begin
                        n_cap_err   = sat_inc(r_cap_err);
                        n_err_total = sat_inc(r_err_total);
                        if (r_s1_want) begin
                            n_o2z = sat_inc(r_o2z);
                        end else begin
                            n_z2o = sat_inc(r_z2o);
                        end
                        n_sum_err = sat_add(r_sum_err, r_s1_margin);
                    end else begin
                        n_sum_ok = sat_add(r_sum_ok, r_s1_margin);
                    end
                end
                n_res.capture_errors = n_cap_err;
                if (r_s1_last) begin
                    if (n_cap_err == '0) begin
                        n_clean = sat_inc(r_clean);
                    end
                    n_cap_err = '0;
                end
            end
            REQ_READ_POS: begin
                if (r_s1_rdok) begin
                    n_res.read_count_a = pe_cur;
                    n_res.read_count_b = pb_cur;
                end
            end
            REQ_READ_HIST: begin
                if (r_s1_hist_rdok) begin
                    n_res.read_count_a = hb_cur;
                end
            end
            default: begin
            end
        endcase

        n_res.total_bits         = n_bit_total;
        n_res.total_errors       = n_err_total;
        n_res.errors_zero_to_one = n_z2o;
        n_res.errors_one_to_zero = n_o2z;
        n_res.margin_sum_correct = n_sum_ok;
        n_res.margin_sum_errored = n_sum_err;
        n_res.clean_captures     = n_clean;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_err   <= '0;
            r_bit_total <= '0;
            r_err_total <= '0;
            r_z2o       <= '0;
            r_o2z       <= '0;
            r_clean     <= '0;
            r_sum_ok    <= '0;
            r_sum_err   <= '0;
        end else if (s1_fire) begin
            r_cap_err   <= n_cap_err;
            r_bit_total <= n_bit_total;
            r_err_total <= n_err_total;
            r_z2o       <= n_z2o;
            r_o2z       <= n_o2z;
            r_clean     <= n_clean;
            r_sum_ok    <= n_sum_ok;
            r_sum_err   <= n_sum_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_move) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_data <= n_res;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run <= RUN_W'(RUN_BINS))
        else $error("open run above top bin");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(MAX_POSITIONS))
        else $error("bit position beyond bound");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_move) |=> (r_s1_vld && $stable(r_s1_req)))
        else $error("stage 1 request lost while output stalled");

    a_err_le_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.total_errors <= o_out_data.total_bits))
        else $error("error total exceeds bit total");

    a_cmp_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.bit_error) |->
            (o_out_data.read_count_a == '0 && o_out_data.read_count_b == '0))
        else $error("compare result carries read data");

endmodule
`default_nettype wire
